// ===== rtl/pp_pkg.sv =====
// shared types, constants and microcode encoding for the pivot partition block
package pp_pkg;

  // store geometry
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 5;

  typedef logic [STEP_W-1:0] step_t;

  // read address sources
  typedef enum logic [2:0] {
    RD_P,
    RD_ZERO,
    RD_I,
    RD_POS,
    RD_POS1
  } rd_sel_t;

  // write address sources
  typedef enum logic [1:0] {
    WA_P,
    WA_ZERO,
    WA_I,
    WA_POS
  } wa_sel_t;

  // write data sources
  typedef enum logic [1:0] {
    WD_A,
    WD_X,
    WD_RDATA
  } wd_sel_t;

  // jump conditions
  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_I_GE_N,
    JMP_GT,
    JMP_NOT_LAST
  } jmp_t;

  // one control word of the program
  typedef struct packed {
    rd_sel_t rd_sel;
    logic    we;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    ld_p;
    logic    ld_x;
    logic    ld_a;
    logic    init_loop;
    logic    init_emit;
    logic    inc_i;
    logic    inc_pos;
    logic    emit;
    logic    done;
    jmp_t    jmp;
    step_t   target;
  } ctl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic i_ge_n;
    logic gt;
    logic last;
  } flags_t;

  localparam ctl_t CTL_NOP = '{
    rd_sel:    RD_P,
    we:        1'b0,
    wa_sel:    WA_P,
    wd_sel:    WD_A,
    ld_p:      1'b0,
    ld_x:      1'b0,
    ld_a:      1'b0,
    init_loop: 1'b0,
    init_emit: 1'b0,
    inc_i:     1'b0,
    inc_pos:   1'b0,
    emit:      1'b0,
    done:      1'b0,
    jmp:       JMP_NONE,
    target:    '0
  };

  // program step addresses
  localparam step_t STEP_CLAMP  = 5'd0;
  localparam step_t STEP_RDP    = 5'd1;
  localparam step_t STEP_RD0    = 5'd2;
  localparam step_t STEP_HOLD0  = 5'd3;
  localparam step_t STEP_WRP    = 5'd4;
  localparam step_t STEP_WR0    = 5'd5;
  localparam step_t STEP_LTEST  = 5'd6;
  localparam step_t STEP_LCMP   = 5'd7;
  localparam step_t STEP_LRDPOS = 5'd8;
  localparam step_t STEP_LWRI   = 5'd9;
  localparam step_t STEP_LWRPOS = 5'd10;
  localparam step_t STEP_LINC   = 5'd11;
  localparam step_t STEP_FRD    = 5'd12;
  localparam step_t STEP_FWR0   = 5'd13;
  localparam step_t STEP_FWRP   = 5'd14;
  localparam step_t STEP_ERD    = 5'd15;
  localparam step_t STEP_EOUT   = 5'd16;
  localparam step_t STEP_DONE   = 5'd17;

endpackage

// ===== rtl/pp_ram.sv =====
// generic single write, single read ram with registered read data
module pp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pp_seq.sv =====
// microcode sequencer: program rom, step counter and conditional jumps
module pp_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  pp_pkg::flags_t flags,
  output pp_pkg::ctl_t   ctl,
  output logic           busy
);

  logic           busy_r;
  pp_pkg::step_t  pc_r;
  pp_pkg::step_t  pc_nxt;
  logic           taken;

  // partition program
  function automatic pp_pkg::ctl_t rom(input pp_pkg::step_t s);
    pp_pkg::ctl_t c;
    c = pp_pkg::CTL_NOP;
    unique case (s)
      // clamp pivot index against the count
      pp_pkg::STEP_CLAMP: begin
        c.ld_p = 1'b1;
      end
      pp_pkg::STEP_RDP: begin
        c.rd_sel = pp_pkg::RD_P;
      end
      // pivot value arrives, fetch entry zero
      pp_pkg::STEP_RD0: begin
        c.rd_sel = pp_pkg::RD_ZERO;
        c.ld_x   = 1'b1;
      end
      pp_pkg::STEP_HOLD0: begin
        c.ld_a = 1'b1;
      end
      // swap pivot to the front
      pp_pkg::STEP_WRP: begin
        c.we     = 1'b1;
        c.wa_sel = pp_pkg::WA_P;
        c.wd_sel = pp_pkg::WD_A;
      end
      pp_pkg::STEP_WR0: begin
        c.we        = 1'b1;
        c.wa_sel    = pp_pkg::WA_ZERO;
        c.wd_sel    = pp_pkg::WD_X;
        c.init_loop = 1'b1;
      end
      // scan loop
      pp_pkg::STEP_LTEST: begin
        c.rd_sel = pp_pkg::RD_I;
        c.jmp    = pp_pkg::JMP_I_GE_N;
        c.target = pp_pkg::STEP_FRD;
      end
      pp_pkg::STEP_LCMP: begin
        c.ld_a   = 1'b1;
        c.jmp    = pp_pkg::JMP_GT;
        c.target = pp_pkg::STEP_LINC;
      end
      pp_pkg::STEP_LRDPOS: begin
        c.rd_sel  = pp_pkg::RD_POS1;
        c.inc_pos = 1'b1;
      end
      pp_pkg::STEP_LWRI: begin
        c.we     = 1'b1;
        c.wa_sel = pp_pkg::WA_I;
        c.wd_sel = pp_pkg::WD_RDATA;
      end
      pp_pkg::STEP_LWRPOS: begin
        c.we     = 1'b1;
        c.wa_sel = pp_pkg::WA_POS;
        c.wd_sel = pp_pkg::WD_A;
        c.inc_i  = 1'b1;
        c.jmp    = pp_pkg::JMP_ALWAYS;
        c.target = pp_pkg::STEP_LTEST;
      end
      pp_pkg::STEP_LINC: begin
        c.inc_i  = 1'b1;
        c.jmp    = pp_pkg::JMP_ALWAYS;
        c.target = pp_pkg::STEP_LTEST;
      end
      // move pivot to its final place
      pp_pkg::STEP_FRD: begin
        c.rd_sel = pp_pkg::RD_POS;
      end
      pp_pkg::STEP_FWR0: begin
        c.we     = 1'b1;
        c.wa_sel = pp_pkg::WA_ZERO;
        c.wd_sel = pp_pkg::WD_RDATA;
      end
      pp_pkg::STEP_FWRP: begin
        c.we        = 1'b1;
        c.wa_sel    = pp_pkg::WA_POS;
        c.wd_sel    = pp_pkg::WD_X;
        c.init_emit = 1'b1;
      end
      // emit loop
      pp_pkg::STEP_ERD: begin
        c.rd_sel = pp_pkg::RD_I;
      end
      pp_pkg::STEP_EOUT: begin
        c.emit   = 1'b1;
        c.inc_i  = 1'b1;
        c.jmp    = pp_pkg::JMP_NOT_LAST;
        c.target = pp_pkg::STEP_ERD;
      end
      pp_pkg::STEP_DONE: begin
        c.done = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

  // current control word, quiet while idle
  always_comb begin
    ctl = busy_r ? rom(pc_r) : pp_pkg::CTL_NOP;
  end

  // jump decision
  always_comb begin
    unique case (ctl.jmp)
      pp_pkg::JMP_NONE:     taken = 1'b0;
      pp_pkg::JMP_ALWAYS:   taken = 1'b1;
      pp_pkg::JMP_I_GE_N:   taken = flags.i_ge_n;
      pp_pkg::JMP_GT:       taken = flags.gt;
      pp_pkg::JMP_NOT_LAST: taken = !flags.last;
      default:              taken = 1'b0;
    endcase
    pc_nxt = taken ? ctl.target : pc_r + pp_pkg::step_t'(1);
  end

  // step counter and run flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= pp_pkg::STEP_CLAMP;
    end else if (!busy_r) begin
      if (go) begin
        busy_r <= 1'b1;
        pc_r   <= pp_pkg::STEP_CLAMP;
      end
    end else begin
      pc_r <= pc_nxt;
      if (ctl.done) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;

endmodule

// ===== rtl/pivot_partition_top.sv =====
// top level of the pivot partition block: load store, datapath and result registers
//
// Usage: elements are sent on in_element with start while busy is low, one
// request per cycle; each is written into a 64-entry store (later ones are
// dropped once it is full). A request with in_final_item high starts a run:
// busy rises, the stored set is partitioned around the element at the
// configured pivot index (clamped to the last element), then every element
// is sent out in position order on out_value / out_position with
// out_pivot_rank, one result per out_strobe pulse, out_run_end marking the
// last. The count then returns to zero and busy falls.
// A run swaps the pivot to the front, scans the other elements (each one
// not above the pivot is swapped into the low part), moves the pivot to
// its final place, then reads out the results and finishes; the single
// read port and single write port of the store pace each of these steps.
// The pivot index register is written through cfg_valid / cfg_pivot_index,
// always ready; write it only while idle.
// Reset clears the count, the pivot index and the result strobe; store
// contents are never cleared. The receiver cannot stall the result stream.
module pivot_partition_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          in_element,
  input  logic                        in_final_item,
  output logic                        out_strobe,
  output logic signed [31:0]          out_value,
  output logic [5:0]                  out_position,
  output logic [5:0]                  out_pivot_rank,
  output logic                        out_run_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [5:0]                  cfg_pivot_index
);

  logic                              accept;
  logic                              go;
  pp_pkg::ctl_t                      ctl;
  pp_pkg::flags_t                    flags;
  logic                              seq_busy;

  logic [5:0]                        pivot_r;
  logic [pp_pkg::CNT_W-1:0]          count_r;
  logic [pp_pkg::ADDR_W-1:0]         p_r;
  logic [pp_pkg::ADDR_W-1:0]         p_nxt;
  logic [pp_pkg::ADDR_W-1:0]         pos_r;
  logic [pp_pkg::ADDR_W-1:0]         pos1;
  logic [pp_pkg::CNT_W-1:0]          i_r;
  logic [pp_pkg::DATA_W-1:0]         x_r;
  logic [pp_pkg::DATA_W-1:0]         a_r;

  logic                              ram_we;
  logic [pp_pkg::ADDR_W-1:0]         ram_waddr;
  logic [pp_pkg::DATA_W-1:0]         ram_wdata;
  logic [pp_pkg::ADDR_W-1:0]         ram_raddr;
  logic [pp_pkg::DATA_W-1:0]         ram_rdata;

  logic                              out_strobe_r;
  logic [pp_pkg::DATA_W-1:0]         out_value_r;
  logic [5:0]                        out_position_r;
  logic [5:0]                        out_pivot_rank_r;
  logic                              out_run_end_r;

  // request handshake
  assign accept = start && !seq_busy;
  assign go     = accept && in_final_item;
  assign busy   = seq_busy;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pivot_r <= cfg_pivot_index;
    end
  end

  pp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .flags (flags),
    .ctl   (ctl),
    .busy  (seq_busy)
  );

  // status for the sequencer
  always_comb begin
    flags.i_ge_n = (i_r >= count_r);
    flags.gt     = ($signed(ram_rdata) > $signed(x_r));
    flags.last   = (i_r == count_r - pp_pkg::CNT_W'(1));
  end

  // pivot clamp against the element count
  always_comb begin
    if ({1'b0, pivot_r} >= count_r) begin
      p_nxt = pp_pkg::ADDR_W'(count_r - pp_pkg::CNT_W'(1));
    end else begin
      p_nxt = pivot_r;
    end
  end

  assign pos1 = pos_r + pp_pkg::ADDR_W'(1);

  // read address select
  always_comb begin
    unique case (ctl.rd_sel)
      pp_pkg::RD_P:    ram_raddr = p_r;
      pp_pkg::RD_ZERO: ram_raddr = '0;
      pp_pkg::RD_I:    ram_raddr = i_r[pp_pkg::ADDR_W-1:0];
      pp_pkg::RD_POS:  ram_raddr = pos_r;
      pp_pkg::RD_POS1: ram_raddr = pos1;
      default:         ram_raddr = '0;
    endcase
  end

  // write port: loading while idle, program writes during a run
  always_comb begin
    if (!seq_busy) begin
      ram_we    = accept && (count_r < pp_pkg::CNT_W'(pp_pkg::MAX_LEN));
      ram_waddr = count_r[pp_pkg::ADDR_W-1:0];
      ram_wdata = in_element;
    end else begin
      ram_we = ctl.we;
      unique case (ctl.wa_sel)
        pp_pkg::WA_P:    ram_waddr = p_r;
        pp_pkg::WA_ZERO: ram_waddr = '0;
        pp_pkg::WA_I:    ram_waddr = i_r[pp_pkg::ADDR_W-1:0];
        pp_pkg::WA_POS:  ram_waddr = pos_r;
        default:         ram_waddr = '0;
      endcase
      unique case (ctl.wd_sel)
        pp_pkg::WD_A:     ram_wdata = a_r;
        pp_pkg::WD_X:     ram_wdata = x_r;
        pp_pkg::WD_RDATA: ram_wdata = ram_rdata;
        default:          ram_wdata = a_r;
      endcase
    end
  end

  pp_ram #(
    .WIDTH (pp_pkg::DATA_W),
    .DEPTH (pp_pkg::MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.done) begin
      count_r <= '0;
    end else if (ram_we && !seq_busy) begin
      count_r <= count_r + pp_pkg::CNT_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.ld_p) begin
      p_r <= p_nxt;
    end
    if (ctl.ld_x) begin
      x_r <= ram_rdata;
    end
    if (ctl.ld_a) begin
      a_r <= ram_rdata;
    end
    if (ctl.init_loop) begin
      i_r   <= pp_pkg::CNT_W'(1);
      pos_r <= '0;
    end else if (ctl.init_emit) begin
      i_r <= '0;
    end else begin
      if (ctl.inc_i) begin
        i_r <= i_r + pp_pkg::CNT_W'(1);
      end
      if (ctl.inc_pos) begin
        pos_r <= pos1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_value_r      <= ram_rdata;
      out_position_r   <= 6'(i_r);
      out_pivot_rank_r <= 6'(pos_r);
      out_run_end_r    <= flags.last;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_value      = out_value_r;
  assign out_position   = out_position_r;
  assign out_pivot_rank = out_pivot_rank_r;
  assign out_run_end    = out_run_end_r;

endmodule

// ===== rtl/pp_checker.sv =====
// port-level checker for the pivot partition block, bound to the top level
module pp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_final_item,
  input logic        out_strobe,
  input logic [5:0]  out_position,
  input logic [5:0]  out_pivot_rank,
  input logic        out_run_end
);

  // results only appear during a run
  a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result outside a run");

  // a final request starts a run
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_final_item) |=> busy)
    else $error("final request did not start a run");

  // results step through consecutive positions
  a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_run_end) |-> ##2
      (out_strobe && out_position == $past(out_position, 2) + 6'd1))
    else $error("result position sequence broken");

  // pivot rank holds across a run
  a_rank_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_position != 6'd0) |->
      (out_pivot_rank == $past(out_pivot_rank, 2)))
    else $error("pivot rank changed within a run");

  // nothing follows the last result
  a_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_run_end) |=> !out_strobe)
    else $error("result after run end");

endmodule

bind pivot_partition_top pp_checker u_pp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_final_item  (in_final_item),
  .out_strobe     (out_strobe),
  .out_position   (out_position),
  .out_pivot_rank (out_pivot_rank),
  .out_run_end    (out_run_end)
);
